@@ src/rnra_pkg.sv @@
// Shared types, constants and ring index helpers for the ring neighbor resource arbiter.
// No dependencies; every other file of the block uses this package.
package rnra_pkg;

  localparam int MAX_SEATS   = 16;
  localparam int SEAT_W      = 4;
  localparam int CNT_W       = 5;
  localparam int ADDR_W      = $clog2(MAX_SEATS);
  localparam int MAX_RESULTS = 3;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
  localparam int WIN_SLOTS   = 5;

  localparam logic [CNT_W-1:0] RESET_SEATS = CNT_W'(16);
  localparam logic [CNT_W-1:0] MIN_RING    = CNT_W'(2);
  localparam logic [CNT_W-1:0] MAX_RING    = CNT_W'(MAX_SEATS);

  typedef enum logic [1:0] {
    SEAT_THINK  = 2'd0,
    SEAT_HUNGRY = 2'd1,
    SEAT_EAT    = 2'd2
  } seat_st_t;

  typedef enum logic [1:0] {
    RES_GRANTED  = 2'd0,
    RES_WAITING  = 2'd1,
    RES_RELEASED = 2'd2,
    RES_IGNORED  = 2'd3
  } res_t;

  localparam logic MODE_REQUEST = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    seat_st_t          wdata;
  } mem_req_t;

  typedef struct packed {
    logic [SEAT_W-1:0] target_seat;
    res_t              event_res;
    logic              last;
  } res_item_t;

  function automatic logic [CNT_W-1:0] left_of(logic [CNT_W-1:0] x, logic [CNT_W-1:0] n);
    return (x == '0) ? (n - CNT_W'(1)) : (x - CNT_W'(1));
  endfunction

  function automatic logic [CNT_W-1:0] right_of(logic [CNT_W-1:0] x, logic [CNT_W-1:0] n);
    return ((x + CNT_W'(1)) >= n) ? '0 : (x + CNT_W'(1));
  endfunction

endpackage

@@ src/rnra_if.sv @@
// Valid/ready channel interfaces for the request input and the result output.
// Depends on rnra_pkg for the field widths.
interface rnra_in_if;
  logic                      valid;
  logic                      ready;
  logic [rnra_pkg::SEAT_W-1:0] seat;
  logic                      mode;

  modport source (output valid, output seat, output mode, input ready);
  modport sink (input valid, input seat, input mode, output ready);
endinterface

interface rnra_out_if;
  logic                      valid;
  logic                      ready;
  logic [rnra_pkg::SEAT_W-1:0] target_seat;
  logic [1:0]                event_res;
  logic                      last;

  modport source (output valid, output target_seat, output event_res, output last, input ready);
  modport sink (input valid, input target_seat, input event_res, input last, output ready);
endinterface

@@ src/rnra_state_mem.sv @@
// Seat state memory: synchronous RAM with registered read data plus per-entry valid bits.
// An entry that was never written since reset reads as thinking. Depends on rnra_pkg.
module rnra_state_mem (
  input  logic               clk,
  input  logic               rst_n,
  input  rnra_pkg::mem_req_t req,
  output rnra_pkg::seat_st_t rdata
);
  import rnra_pkg::*;

  seat_st_t             mem_r [MAX_SEATS];
  logic [MAX_SEATS-1:0] vld_r;
  seat_st_t             rd_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_r     <= mem_r[req.raddr];
      rd_vld_r <= vld_r[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.we) begin
      vld_r[req.waddr] <= 1'b1;
    end
  end

  assign rdata = rd_vld_r ? rd_r : SEAT_THINK;

endmodule

@@ src/rnra_out_fifo.sv @@
// Result queue between the sequencer and the output channel.
// Holds up to FIFO_DEPTH result transactions. Depends on rnra_pkg and rnra_out_if.
module rnra_out_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  rnra_pkg::res_item_t     push_item,
  output logic [rnra_pkg::FIFO_CW-1:0] count,
  rnra_out_if.source              out_ch
);
  import rnra_pkg::*;

  res_item_t          buf_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic               pop;

  assign pop                = out_ch.valid && out_ch.ready;
  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.target_seat = buf_r[rd_ptr_r].target_seat;
  assign out_ch.event_res   = buf_r[rd_ptr_r].event_res;
  assign out_ch.last        = buf_r[rd_ptr_r].last;
  assign count              = cnt_r;

  always_comb begin
    wr_ptr_nxt = push ? (wr_ptr_r + FIFO_AW'(1)) : wr_ptr_r;
    rd_ptr_nxt = pop ? (rd_ptr_r + FIFO_AW'(1)) : rd_ptr_r;
    cnt_nxt    = cnt_r + FIFO_CW'(push) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ src/rnra_seq.sv @@
// Event sequencer: reads the five-seat neighborhood from the state memory, decides the
// grants and writes the changed seats back. Depends on rnra_pkg and rnra_in_if.
module rnra_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  rnra_in_if.sink                     in_ch,
  input  logic                        cfg_we,
  input  logic [rnra_pkg::CNT_W-1:0]  cfg_wdata,
  output rnra_pkg::mem_req_t          mem_req,
  input  rnra_pkg::seat_st_t          mem_rdata,
  input  logic [rnra_pkg::FIFO_CW-1:0] fifo_cnt,
  output logic                        res_push,
  output rnra_pkg::res_item_t         res_item
);
  import rnra_pkg::*;

  typedef enum logic [3:0] {
    SQ_IDLE  = 4'b0001,
    SQ_READ  = 4'b0010,
    SQ_DRAIN = 4'b0100,
    SQ_WB    = 4'b1000
  } sq_state_t;

  localparam logic [FIFO_CW-1:0] FIFO_ROOM = FIFO_CW'(FIFO_DEPTH - MAX_RESULTS);
  localparam logic [2:0]         LAST_RD   = 3'(WIN_SLOTS - 1);
  localparam logic [2:0]         LAST_WB   = 3'(MAX_RESULTS - 1);

  sq_state_t         state_r, state_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] idx_r [WIN_SLOTS];
  logic [ADDR_W-1:0] idx_nxt [WIN_SLOTS];
  seat_st_t          win_r [WIN_SLOTS];
  seat_st_t          win_nxt [WIN_SLOTS];
  logic              mode_r, mode_nxt;
  logic              pend_r, pend_nxt;
  logic [2:0]        slot_r, slot_nxt;
  logic [CNT_W-1:0]  seats_r, seats_nxt;

  logic [CNT_W-1:0]  ring_n;
  logic [CNT_W-1:0]  s_c, l_c, ll_c, r_c, rr_c;
  logic              accept;
  logic              in_range;
  logic              ign, grant_s, grant_l, grant_r;
  seat_st_t          new_s;
  seat_st_t          st_a [WIN_SLOTS];
  seat_st_t          st_b [WIN_SLOTS];
  seat_st_t          st_c [WIN_SLOTS];
  logic [2:0]        wb_slot;

  always_comb begin
    if (seats_r < MIN_RING) begin
      ring_n = MIN_RING;
    end else if (seats_r > MAX_RING) begin
      ring_n = MAX_RING;
    end else begin
      ring_n = seats_r;
    end
  end

  assign in_ch.ready = (state_r == SQ_IDLE) && (fifo_cnt <= FIFO_ROOM);
  assign accept      = in_ch.valid && in_ch.ready;
  assign s_c         = {1'b0, in_ch.seat};
  assign in_range    = s_c < ring_n;
  assign l_c         = left_of(s_c, ring_n);
  assign ll_c        = left_of(l_c, ring_n);
  assign r_c         = right_of(s_c, ring_n);
  assign rr_c        = right_of(r_c, ring_n);

  // Slot 2 is the seat itself; slots 1 and 3 its neighbors, 0 and 4 theirs.
  // Small rings alias slots, so every update is applied to all slots of that seat.
  always_comb begin
    ign     = (mode_r == MODE_REQUEST) ? (win_r[2] != SEAT_THINK) : (win_r[2] != SEAT_EAT);
    grant_s = (win_r[1] != SEAT_EAT) && (win_r[3] != SEAT_EAT);
    new_s   = (mode_r == MODE_RELEASE) ? SEAT_THINK : (grant_s ? SEAT_EAT : SEAT_HUNGRY);
    for (int i = 0; i < WIN_SLOTS; i++) begin
      st_a[i] = (idx_r[i] == idx_r[2]) ? new_s : win_r[i];
    end
    grant_l = (mode_r == MODE_RELEASE) && !ign && (st_a[1] == SEAT_HUNGRY) &&
              (st_a[0] != SEAT_EAT) && (st_a[2] != SEAT_EAT);
    for (int i = 0; i < WIN_SLOTS; i++) begin
      st_b[i] = (grant_l && (idx_r[i] == idx_r[1])) ? SEAT_EAT : st_a[i];
    end
    grant_r = (mode_r == MODE_RELEASE) && !ign && (st_b[3] == SEAT_HUNGRY) &&
              (st_b[2] != SEAT_EAT) && (st_b[4] != SEAT_EAT);
    for (int i = 0; i < WIN_SLOTS; i++) begin
      st_c[i] = (grant_r && (idx_r[i] == idx_r[3])) ? SEAT_EAT : st_b[i];
    end
  end

  assign wb_slot = cnt_r + 3'd1;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mode_nxt  = mode_r;
    pend_nxt  = 1'b0;
    slot_nxt  = slot_r;
    seats_nxt = cfg_we ? cfg_wdata : seats_r;
    for (int i = 0; i < WIN_SLOTS; i++) begin
      idx_nxt[i] = idx_r[i];
      win_nxt[i] = win_r[i];
    end
    if (pend_r) begin
      win_nxt[slot_r] = mem_rdata;
    end
    mem_req       = '0;
    mem_req.raddr = idx_r[cnt_r];
    mem_req.waddr = idx_r[wb_slot];
    mem_req.wdata = st_c[wb_slot];
    res_push      = 1'b0;
    res_item      = '0;

    case (state_r)
      SQ_IDLE: begin
        if (accept) begin
          if (in_range) begin
            idx_nxt[0] = ll_c[ADDR_W-1:0];
            idx_nxt[1] = l_c[ADDR_W-1:0];
            idx_nxt[2] = s_c[ADDR_W-1:0];
            idx_nxt[3] = r_c[ADDR_W-1:0];
            idx_nxt[4] = rr_c[ADDR_W-1:0];
            mode_nxt   = in_ch.mode;
            cnt_nxt    = '0;
            state_nxt  = SQ_READ;
          end else begin
            res_push             = 1'b1;
            res_item.target_seat = in_ch.seat;
            res_item.event_res   = RES_IGNORED;
            res_item.last        = 1'b1;
          end
        end
      end
      SQ_READ: begin
        mem_req.re = 1'b1;
        pend_nxt   = 1'b1;
        slot_nxt   = cnt_r;
        if (cnt_r == LAST_RD) begin
          cnt_nxt   = '0;
          state_nxt = SQ_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      SQ_DRAIN: begin
        cnt_nxt   = '0;
        state_nxt = SQ_WB;
      end
      SQ_WB: begin
        mem_req.we = !ign;
        case (cnt_r)
          3'd0: begin
            res_push             = 1'b1;
            res_item.target_seat = idx_r[2];
            if (ign) begin
              res_item.event_res = RES_IGNORED;
            end else if (mode_r == MODE_RELEASE) begin
              res_item.event_res = RES_RELEASED;
            end else begin
              res_item.event_res = grant_s ? RES_GRANTED : RES_WAITING;
            end
            res_item.last = !grant_l && !grant_r;
          end
          3'd1: begin
            res_push             = grant_l;
            res_item.target_seat = idx_r[1];
            res_item.event_res   = RES_GRANTED;
            res_item.last        = !grant_r;
          end
          default: begin
            res_push             = grant_r;
            res_item.target_seat = idx_r[3];
            res_item.event_res   = RES_GRANTED;
            res_item.last        = 1'b1;
          end
        endcase
        if (cnt_r == LAST_WB) begin
          cnt_nxt   = '0;
          state_nxt = SQ_IDLE;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      default: begin
        state_nxt = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WIN_SLOTS; i++) begin
      idx_r[i] <= idx_nxt[i];
      win_r[i] <= win_nxt[i];
    end
    mode_r <= mode_nxt;
    slot_r <= slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      seats_r <= RESET_SEATS;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      seats_r <= seats_nxt;
    end
  end

  a_write_only_in_wb: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r == SQ_WB))
    else $error("state memory written outside write-back");

  a_no_fifo_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (fifo_cnt != FIFO_CW'(FIFO_DEPTH)))
    else $error("result pushed into a full queue");

  a_accept_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (state_r == SQ_IDLE))
    else $error("transaction accepted while busy");

  a_drain_then_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SQ_DRAIN) |=> (state_r == SQ_WB) && pend_r == 1'b0)
    else $error("read drain not followed by write-back");

endmodule

@@ src/ring_neighbor_resource_arbiter.sv @@
// Ring neighbor resource arbiter, top level.
// Clients sit in a ring; each shares a resource with its left and right neighbor.
// in_ch carries one event transaction (seat, mode): mode 0 requests, mode 1 releases.
// out_ch returns one to three result transactions per event (target_seat, event_res,
// last), with last set on the final one. A request gives granted, waiting or ignored;
// a release gives released, then granted for the left and for the right neighbor when
// those waiting clients can now proceed, or only ignored when the seat is not eating.
// cfg_we/cfg_wdata set the ring size, which is clamped to 2..16; write it only while
// no event is in flight. An event in the ring makes five reads of the seat neighborhood
// from the one-port-read state memory, waits in a drain state for the last read data,
// then writes back the seat and its neighbors while queueing the results. An event
// for a seat outside the ring yields ignored straight from the idle state.
// Results go through a four-entry queue, so a stalled receiver holds results there;
// new events are accepted only while idle and at least three entries are free.
// Reset (rst_n low at a clock edge) sets every seat to thinking and the ring size to 16.
module ring_neighbor_resource_arbiter (
  input  logic                       clk,
  input  logic                       rst_n,
  rnra_in_if.sink                    in_ch,
  rnra_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [rnra_pkg::CNT_W-1:0] cfg_wdata
);
  import rnra_pkg::*;

  mem_req_t           mem_req;
  seat_st_t           mem_rdata;
  logic [FIFO_CW-1:0] fifo_cnt;
  logic               res_push;
  res_item_t          res_item;

  rnra_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .fifo_cnt  (fifo_cnt),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  rnra_state_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  rnra_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_item (res_item),
    .count     (fifo_cnt),
    .out_ch    (out_ch)
  );

endmodule
